// ===== design/case_folding_regex_line_matcher_defines.svh =====
// assertion macros for the line matcher
`ifndef CASE_FOLDING_REGEX_LINE_MATCHER_DEFINES_SVH
`define CASE_FOLDING_REGEX_LINE_MATCHER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CFRLM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("line matcher check failed");
// next-cycle implication
`define CFRLM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("line matcher check failed");
`else
`define CFRLM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CFRLM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/cfrlm_pkg.sv =====
package cfrlm_pkg;

	localparam int DEF_PATTERN_ELEMENTS = 32;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [7:0] UPPER_A  = 8'o101;
	localparam logic [7:0] UPPER_Z  = 8'o132;
	localparam logic [7:0] CASE_GAP = 8'o040;

	// word opcodes
	typedef enum logic [2:0] {
		OP_CLEAR  = 3'd0,
		OP_APPEND = 3'd1,
		OP_MEMBER = 3'd2,
		OP_BYTE   = 3'd3,
		OP_EOL    = 3'd4
	} op_t;

	// element kinds
	typedef enum logic [1:0] {
		KIND_LITERAL = 2'd0,
		KIND_ANY     = 2'd1,
		KIND_CLASS   = 2'd2,
		KIND_NCLASS  = 2'd3
	} kind_t;

	// register indexes
	typedef enum logic {
		REG_ANCHOR_START = 1'b0,
		REG_ANCHOR_END   = 1'b1
	} reg_idx_t;

	// broadcast commands from the control to every cell
	typedef struct packed {
		logic step;     // advance on a line character
		logic restart;  // drop all active positions
		logic clear;    // wipe class members
		logic append;   // store a new element at the tail
		logic member;   // add a class member to the last element
	} cell_cmd_t;

	// fold upper case to lower case
	function automatic logic [7:0] fold(input logic [7:0] c);
		return (c >= UPPER_A && c <= UPPER_Z) ? c + CASE_GAP : c;
	endfunction

endpackage

// ===== design/cfrlm_cell.sv =====
module cfrlm_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  cfrlm_pkg::cell_cmd_t cmd,
	input  logic               is_tail,
	input  logic               is_last,
	input  logic               en,
	input  logic [7:0]         data_byte,
	input  cfrlm_pkg::kind_t   kind_in,
	input  logic               repeat_in,
	input  logic               closed_in,
	input  logic               adv_in,
	output logic               closed,
	output logic               closed_out,
	output logic               adv_out
);
	import cfrlm_pkg::*;

	kind_t        kind_q;
	logic         rep_q;
	logic [7:0]   lit_q;
	logic [255:0] class_q;
	logic         raw_q;
	logic [7:0]   folded;
	logic         inset;
	logic         hit;

	// element payload, written on append
	always_ff @(posedge clk) begin
		if (cmd.append && is_tail) begin
			kind_q <= kind_in;
			rep_q  <= repeat_in;
			lit_q  <= data_byte;
		end
	end

	// class member set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_q <= '0;
		end else if (cmd.clear) begin
			class_q <= '0;
		end else if (cmd.member && is_last) begin
			class_q[data_byte] <= 1'b1;
		end
	end

	// character test against this element
	assign folded = fold(data_byte);
	assign inset  = class_q[data_byte] | class_q[folded];

	always_comb begin
		case (kind_q)
			KIND_LITERAL: hit = (data_byte == lit_q) || (folded == lit_q);
			KIND_ANY:     hit = (data_byte != 8'd0);
			KIND_CLASS:   hit = (data_byte != 8'd0) && inset;
			KIND_NCLASS:  hit = (data_byte != 8'd0) && !inset;
			default:      hit = 1'b0;
		endcase
	end

	// closure link and advance to the neighbour
	assign closed     = raw_q | closed_in;
	assign closed_out = closed & rep_q & en;
	assign adv_out    = closed & hit & !rep_q & en;

	// active position bit, before closure
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q <= 1'b0;
		end else if (cmd.restart) begin
			raw_q <= 1'b0;
		end else if (cmd.step) begin
			raw_q <= adv_in | (closed & hit & rep_q & en);
		end
	end

endmodule

// ===== design/case_folding_regex_line_matcher.sv =====
// Case-folding line matcher: a row of NFA cells, one per pattern element.
// Input channel (item_valid/item_ready) carries one word per cycle while item_ready
// is high: clear, append element, add class member, line character or end of line.
// Output channel (result_valid/result_ready) carries matched and
// pattern_overflow, one result per end-of-line word only.
// One word is accepted per cycle while item_ready is high; the result
// of an end-of-line word is shown in the cycle after it is accepted.
// The cycle time is set by the closure link that ripples through the row of
// cells, followed by the element test and the next-state write.
// While a result waits, words other than end of line are still accepted;
// another end-of-line word waits until the result is taken.
// Reset empties the pattern, clears class members and the overflow flag,
// clears both anchor registers and leaves no result pending.
// anchor_start sits at byte address 0 and anchor_end at 4 on the APB port;
// write them only while the block is idle.
module case_folding_regex_line_matcher #(
	parameter int PATTERN_ELEMENTS = cfrlm_pkg::DEF_PATTERN_ELEMENTS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  logic [2:0]                     opcode,
	input  logic [7:0]                     data_byte,
	input  logic [1:0]                     element_kind,
	input  logic                           repeat_flag,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic                           matched,
	output logic                           pattern_overflow,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cfrlm_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [cfrlm_pkg::APB_DATA_W-1:0] pwdata,
	output logic [cfrlm_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	`include "case_folding_regex_line_matcher_defines.svh"
	import cfrlm_pkg::*;

	localparam int N  = PATTERN_ELEMENTS;
	localparam int TW = $clog2(N + 1);

	logic          anchor_start_q;
	logic          anchor_end_q;
	logic [TW-1:0] total_q;
	logic          overflow_q;
	logic          match_q;
	logic          start_q;
	logic          acc_raw_q;
	logic          result_valid_q;
	logic          matched_q;
	logic          overflow_out_q;

	logic          item_go;
	logic          cfg_wr;
	reg_idx_t      cfg_idx;
	logic          is_byte;
	logic          is_restart;
	logic          full;
	logic          accept_now;
	cell_cmd_t     cmd;

	logic [N:0]    closed;
	logic [N-1:0]  closed_out;
	logic [N-1:0]  adv_out;

	// configuration registers
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_start_q <= 1'b0;
			anchor_end_q   <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_ANCHOR_START: anchor_start_q <= pwdata[0];
				REG_ANCHOR_END:   anchor_end_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			REG_ANCHOR_START: prdata[0] = anchor_start_q;
			REG_ANCHOR_END:   prdata[0] = anchor_end_q;
			default:          prdata[0] = 1'b0;
		endcase
	end

	// input handshake and word decode
	assign item_ready = !result_valid_q || result_ready || (opcode != OP_EOL);
	assign item_go    = item_valid && item_ready;
	assign full       = (total_q == TW'(N));

	always_comb begin
		is_byte    = 1'b0;
		is_restart = 1'b0;
		unique case (opcode)
			OP_CLEAR, OP_APPEND, OP_MEMBER, OP_EOL: is_restart = item_go;
			OP_BYTE: is_byte = item_go && (data_byte != 8'd0);
			default: ;
		endcase
	end

	always_comb begin
		cmd.step    = is_byte;
		cmd.restart = is_restart;
		cmd.clear   = item_go && (opcode == OP_CLEAR);
		cmd.append  = item_go && (opcode == OP_APPEND) && !full;
		cmd.member  = item_go && (opcode == OP_MEMBER) && (total_q != '0) && !overflow_q;
	end

	// row of element cells
	genvar gi;
	generate
		for (gi = 0; gi < N; gi++) begin : g_cell
			logic c_in;
			logic a_in;
			if (gi == 0) begin : g_head
				assign c_in = start_q;
				assign a_in = 1'b0;
			end else begin : g_body
				assign c_in = closed_out[gi-1];
				assign a_in = adv_out[gi-1];
			end
			cfrlm_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cmd        (cmd),
				.is_tail    (total_q == TW'(gi)),
				.is_last    (total_q == TW'(gi + 1)),
				.en         (total_q > TW'(gi)),
				.data_byte  (data_byte),
				.kind_in    (kind_t'(element_kind)),
				.repeat_in  (repeat_flag),
				.closed_in  (c_in),
				.adv_in     (a_in),
				.closed     (closed[gi]),
				.closed_out (closed_out[gi]),
				.adv_out    (adv_out[gi])
			);
		end
	endgenerate

	// accept position sits past the last element
	assign closed[N]  = acc_raw_q | closed_out[N-1];
	assign accept_now = closed[total_q];

	// pattern length, flags and line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= '0;
			overflow_q <= 1'b0;
			match_q    <= 1'b0;
			start_q    <= 1'b1;
			acc_raw_q  <= 1'b0;
		end else begin
			if (cmd.clear) begin
				total_q    <= '0;
				overflow_q <= 1'b0;
			end else if (item_go && opcode == OP_APPEND) begin
				if (full) begin
					overflow_q <= 1'b1;
				end else begin
					total_q <= total_q + TW'(1);
				end
			end
			if (is_restart) begin
				match_q   <= 1'b0;
				start_q   <= 1'b1;
				acc_raw_q <= 1'b0;
			end else if (is_byte) begin
				match_q   <= match_q | accept_now;
				start_q   <= !anchor_start_q;
				acc_raw_q <= adv_out[N-1];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (item_go && opcode == OP_EOL) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_go && opcode == OP_EOL) begin
			matched_q      <= anchor_end_q ? accept_now : (match_q | accept_now);
			overflow_out_q <= overflow_q;
		end
	end

	assign result_valid     = result_valid_q;
	assign matched          = matched_q;
	assign pattern_overflow = overflow_out_q;

	// checks
	`CFRLM_ASSERT_IMP(a_total_range, clk, arst_n, 1'b1, total_q <= TW'(N))
	`CFRLM_ASSERT_NXT(a_overflow_on_full, clk, arst_n, item_go && opcode == OP_APPEND && full, overflow_q)
	`CFRLM_ASSERT_IMP(a_no_active_past_end, clk, arst_n, 1'b1, ((closed >> total_q) >> 1) == '0)
	`CFRLM_ASSERT_NXT(a_clear_restarts, clk, arst_n, cmd.clear, total_q == '0 && closed == (N+1)'(1))

endmodule
